FILE: sv/utf8dv_pkg.sv
// ----------------------------------------------------------------------------
// utf8dv_pkg
// Shared types and constants of the UTF-8 stream decoder and validator.
// ----------------------------------------------------------------------------
package utf8dv_pkg;

  localparam int OFFSET_BITS  = 32;
  localparam int CP_BITS      = 21;
  localparam int CNT_BITS     = 32;
  localparam int OUT_OFF_BITS = 32;
  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);

  localparam logic [CP_BITS-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_BITS-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_BITS-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_BITS-1:0] MIN_CP_2   = 21'h000080;
  localparam logic [CP_BITS-1:0] MIN_CP_3   = 21'h000800;
  localparam logic [CP_BITS-1:0] MIN_CP_4   = 21'h010000;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]    CNT_MAX = {CNT_BITS{1'b1}};

  // One accepted byte's worth of results: a run of replacement results
  // for the bytes of a failed sequence, then at most one main result.
  typedef struct packed {
    logic [2:0]              flush_cnt;
    logic [OFFSET_BITS-1:0]  flush_off;
    logic                    has_main;
    logic [CP_BITS-1:0]      main_cp;
    logic                    main_bad;
    logic [2:0]              main_len;
    logic [OFFSET_BITS-1:0]  main_off;
    logic [2:0]              total;
    logic [CNT_BITS-1:0]     base_idx;
    logic                    fin;
    logic                    text_valid;
    logic [OUT_OFF_BITS-1:0] first_bad;
  } job_t;

  function automatic logic [OUT_OFF_BITS-1:0] off_to_out(input logic [OFFSET_BITS-1:0] o);
    logic [63:0] t;
    t = 64'(o);
    return t[OUT_OFF_BITS-1:0];
  endfunction

endpackage

FILE: sv/utf8_stream_decode_validate_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate_unit
// UTF-8 stream decoder and validator, one byte in per cycle.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): one text byte per transfer, with
// final_byte_i set on the last byte of a text. The classifier handles a byte
// in its transfer cycle and writes its job, if any, into a four-entry queue.
// Output channel (out_valid_o / out_ready_i): one decoded codepoint or one
// U+FFFD replacement per transfer, with offsets, running index, and on the
// last result of a text the validity summary.
// Path: a result's job is registered in the job queue, then in the
// sequencer's current-job register, which drives the outputs.
// Throughput: one byte per cycle and one result per cycle; a byte that breaks
// a long sequence can produce up to four results, which the sequencer drains
// one per cycle, so input stalls only once the job queue is full.
// Receiver stall: the current result holds steady; bytes keep being taken
// until the queue fills, then in_ready_o drops.
// Reset: the queue empties and decoding starts a new text at offset 0; after
// every final byte, decoding also starts a new text at offset 0.
// ----------------------------------------------------------------------------
module utf8_stream_decode_validate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] codepoint_o,
  output logic        malformed_o,
  output logic [2:0]  seq_bytes_o,
  output logic [31:0] seq_offset_o,
  output logic [31:0] cp_index_o,
  output logic        run_last_o,
  output logic        text_end_o,
  output logic        text_valid_o,
  output logic [31:0] first_bad_offset_o
);
  import utf8dv_pkg::*;

  job_t push_job, pop_job;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;

  utf8dv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .final_byte_i (final_byte_i),
    .job_valid_o  (push_valid),
    .job_ready_i  (push_ready),
    .job_o        (push_job)
  );

  utf8dv_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  utf8dv_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (pop_valid),
    .job_ready_o        (pop_ready),
    .job_i              (pop_job),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .codepoint_o        (codepoint_o),
    .malformed_o        (malformed_o),
    .seq_bytes_o        (seq_bytes_o),
    .seq_offset_o       (seq_offset_o),
    .cp_index_o         (cp_index_o),
    .run_last_o         (run_last_o),
    .text_end_o         (text_end_o),
    .text_valid_o       (text_valid_o),
    .first_bad_offset_o (first_bad_offset_o)
  );

endmodule

FILE: sv/utf8dv_job_fifo.sv
// ----------------------------------------------------------------------------
// utf8dv_job_fifo
// Small job queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
module utf8dv_job_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  utf8dv_pkg::job_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output utf8dv_pkg::job_t  pop_data_o
);
  import utf8dv_pkg::*;

  job_t                  mem_q [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wptr_q, wptr_d;
  logic [JOB_PTR_BITS-1:0] rptr_q, rptr_d;
  logic [JOB_PTR_BITS:0]   cnt_q, cnt_d;
  logic                    push, pop;

  assign push_ready_o = (cnt_q != (JOB_PTR_BITS+1)'(JOB_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/utf8dv_front.sv
// ----------------------------------------------------------------------------
// utf8dv_front
// Byte classifier: tracks the open sequence; bytes with results become jobs.
// ----------------------------------------------------------------------------
module utf8dv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_value_i,
  input  logic              final_byte_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output utf8dv_pkg::job_t  job_o
);
  import utf8dv_pkg::*;

  logic [1:0]             pend_q, pend_d;
  logic [2:0]             width_q, width_d;
  logic [CP_BITS-1:0]     part_q, part_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [CNT_BITS-1:0]    rcnt_q, rcnt_d;
  logic                   err_q, err_d;
  logic [OFFSET_BITS-1:0] errpos_q, errpos_d;

  logic                   accept;
  logic                   is_cont;
  logic                   fresh;
  logic [2:0]             held;
  logic [CP_BITS-1:0]     part_new;
  logic                   overlong;
  logic                   scalar;
  logic [2:0]             lead_w;
  logic [CP_BITS-1:0]     lead_bits;
  logic [OFFSET_BITS:0]   pos_sum;
  logic [CNT_BITS:0]      cnt_sum;
  job_t                   job;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = accept && (job.total != 3'd0);
  assign job_o       = job;
  assign is_cont     = (byte_value_i[7:6] == 2'b10);

  always_comb begin
    held      = 3'(pend_q) + 3'd1;
    part_new  = {part_q[CP_BITS-7:0], byte_value_i[5:0]};
    overlong  = ((width_q == 3'd2) && (part_new < MIN_CP_2)) ||
                ((width_q == 3'd3) && (part_new < MIN_CP_3)) ||
                ((width_q == 3'd4) && (part_new < MIN_CP_4));
    scalar    = (part_new <= CP_MAX) && ((part_new < SURR_LO) || (part_new > SURR_HI));
    lead_w    = 3'd0;
    lead_bits = '0;
    if (byte_value_i[7:5] == 3'b110) begin
      lead_w    = 3'd2;
      lead_bits = CP_BITS'(byte_value_i[4:0]);
    end else if (byte_value_i[7:4] == 4'b1110) begin
      lead_w    = 3'd3;
      lead_bits = CP_BITS'(byte_value_i[3:0]);
    end else if (byte_value_i[7:3] == 5'b11110) begin
      lead_w    = 3'd4;
      lead_bits = CP_BITS'(byte_value_i[2:0]);
    end
  end

  always_comb begin
    pend_d   = pend_q;
    width_d  = width_q;
    part_d   = part_q;
    start_d  = start_q;
    pos_d    = pos_q;
    rcnt_d   = rcnt_q;
    err_d    = err_q;
    errpos_d = errpos_q;
    job      = '0;
    fresh    = 1'b1;
    pos_sum  = {1'b0, pos_q} + 1'b1;
    cnt_sum  = '0;

    job.flush_off = start_q;
    job.base_idx  = rcnt_q;
    job.fin       = final_byte_i;

    if (pend_q != 2'd0) begin
      if (is_cont) begin
        fresh  = 1'b0;
        part_d = part_new;
        if (held >= width_q) begin
          if (!overlong && scalar) begin
            job.has_main = 1'b1;
            job.main_cp  = part_new;
            job.main_len = width_q;
            job.main_off = start_q;
          end else begin
            job.flush_cnt = width_q;
          end
          pend_d = 2'd0;
        end else if (final_byte_i) begin
          job.flush_cnt = held;
          pend_d        = 2'd0;
        end else begin
          pend_d = held[1:0];
        end
      end else begin
        job.flush_cnt = 3'(pend_q);
        pend_d        = 2'd0;
      end
    end

    if (fresh) begin
      if (!byte_value_i[7]) begin
        job.has_main = 1'b1;
        job.main_cp  = CP_BITS'(byte_value_i);
        job.main_len = 3'd1;
        job.main_off = pos_q;
      end else if ((lead_w == 3'd0) || final_byte_i) begin
        job.has_main = 1'b1;
        job.main_cp  = REPL_CP;
        job.main_bad = 1'b1;
        job.main_len = 3'd1;
        job.main_off = pos_q;
      end else begin
        pend_d  = 2'd1;
        width_d = lead_w;
        part_d  = lead_bits;
        start_d = pos_q;
      end
    end

    job.total = job.flush_cnt + 3'(job.has_main);

    // first bad offset: flushed bytes come ahead of the main result
    if (!err_q) begin
      if (job.flush_cnt != 3'd0) begin
        err_d    = 1'b1;
        errpos_d = start_q;
      end else if (job.has_main && job.main_bad) begin
        err_d    = 1'b1;
        errpos_d = pos_q;
      end
    end
    job.text_valid = final_byte_i && !err_d;
    job.first_bad  = (final_byte_i && err_d) ? off_to_out(errpos_d) : '0;

    cnt_sum = {1'b0, rcnt_q} + (CNT_BITS+1)'(job.total);
    rcnt_d  = cnt_sum[CNT_BITS] ? CNT_MAX : cnt_sum[CNT_BITS-1:0];
    pos_d   = pos_sum[OFFSET_BITS] ? OFF_MAX : pos_sum[OFFSET_BITS-1:0];

    if (final_byte_i) begin
      pend_d   = 2'd0;
      width_d  = 3'd1;
      part_d   = '0;
      start_d  = '0;
      pos_d    = '0;
      rcnt_d   = '0;
      err_d    = 1'b0;
      errpos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      width_q  <= 3'd1;
      part_q   <= '0;
      start_q  <= '0;
      pos_q    <= '0;
      rcnt_q   <= '0;
      err_q    <= 1'b0;
      errpos_q <= '0;
    end else if (accept) begin
      pend_q   <= pend_d;
      width_q  <= width_d;
      part_q   <= part_d;
      start_q  <= start_d;
      pos_q    <= pos_d;
      rcnt_q   <= rcnt_d;
      err_q    <= err_d;
      errpos_q <= errpos_d;
    end
  end

endmodule

FILE: sv/utf8dv_back.sv
// ----------------------------------------------------------------------------
// utf8dv_back
// Result sequencer: turns each job into its results, one per unstalled cycle.
// ----------------------------------------------------------------------------
module utf8dv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  utf8dv_pkg::job_t  job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [20:0]       codepoint_o,
  output logic              malformed_o,
  output logic [2:0]        seq_bytes_o,
  output logic [31:0]       seq_offset_o,
  output logic [31:0]       cp_index_o,
  output logic              run_last_o,
  output logic              text_end_o,
  output logic              text_valid_o,
  output logic [31:0]       first_bad_offset_o
);
  import utf8dv_pkg::*;

  job_t                 cur_q, cur_d;
  logic                 vld_q, vld_d;
  logic [1:0]           k_q, k_d;
  logic                 is_last;
  logic                 is_flush;
  logic                 load;
  logic [OFFSET_BITS:0] off_sum;
  logic [CNT_BITS:0]    idx_sum;

  assign is_last     = (3'(k_q) == (cur_q.total - 3'd1));
  assign is_flush    = (3'(k_q) < cur_q.flush_cnt);
  assign load        = !vld_q || (out_ready_i && is_last);
  assign job_ready_o = load;
  assign out_valid_o = vld_q;

  always_comb begin
    cur_d = cur_q;
    vld_d = vld_q;
    k_d   = k_q;
    if (load) begin
      cur_d = job_i;
      vld_d = job_valid_i;
      k_d   = 2'd0;
    end else if (out_ready_i) begin
      k_d = k_q + 2'd1;
    end
  end

  always_comb begin
    off_sum = {1'b0, cur_q.flush_off} + (OFFSET_BITS+1)'(k_q);
    idx_sum = {1'b0, cur_q.base_idx} + (CNT_BITS+1)'(k_q);
    if (is_flush) begin
      codepoint_o  = REPL_CP;
      malformed_o  = 1'b1;
      seq_bytes_o  = 3'd1;
      seq_offset_o = off_to_out(off_sum[OFFSET_BITS] ? OFF_MAX : off_sum[OFFSET_BITS-1:0]);
    end else begin
      codepoint_o  = cur_q.main_cp;
      malformed_o  = cur_q.main_bad;
      seq_bytes_o  = cur_q.main_len;
      seq_offset_o = off_to_out(cur_q.main_off);
    end
    cp_index_o         = idx_sum[CNT_BITS] ? CNT_MAX : idx_sum[CNT_BITS-1:0];
    run_last_o         = is_last;
    text_end_o         = is_last && cur_q.fin;
    text_valid_o       = is_last && cur_q.text_valid;
    first_bad_offset_o = is_last ? cur_q.first_bad : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= 2'd0;
    end else begin
      vld_q <= vld_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UTF-8 stream decoder and validator. Texts are sent as
// bytes: a short set of hand-picked texts first, then random ones built
// mostly from well-formed characters, with overlong, surrogate, out-of-range,
// truncated and noise bytes mixed in. A scoreboard decodes every accepted
// byte and checks each result in order. Sender idling and receiver stalls
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import utf8dv_pkg::*;

  typedef struct packed {
    logic [20:0] cp;
    logic        bad;
    logic [2:0]  len;
    logic [31:0] off;
    logic [31:0] idx;
    logic        run_last;
    logic        text_end;
    logic        text_valid;
    logic [31:0] first_bad;
  } decode_result_t;

  class utf8_scoreboard;
    int unsigned      held_cnt;
    int unsigned      seq_width;
    logic [20:0]      acc;
    logic [31:0]      lead_off;
    logic [31:0]      next_off;
    logic [31:0]      res_count;
    bit               err_flag;
    logic [31:0]      err_off;
    decode_result_t   due_q[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      held_cnt  = 0;
      seq_width = 1;
      acc       = '0;
      lead_off  = '0;
      next_off  = '0;
      res_count = '0;
      err_flag  = 1'b0;
      err_off   = '0;
    endfunction

    function logic [31:0] off_plus(logic [31:0] base, int unsigned k);
      logic [32:0] s;
      s = {1'b0, base} + 33'(k);
      return (s > {1'b0, OFF_MAX}) ? OFF_MAX : s[31:0];
    endfunction

    function void add_result(logic [20:0] cp, bit bad, logic [2:0] len, logic [31:0] off);
      decode_result_t r;
      r     = '0;
      r.cp  = cp;
      r.bad = bad;
      r.len = len;
      r.off = off;
      r.idx = res_count;
      if (res_count != CNT_MAX) res_count = res_count + 1;
      if (bad && !err_flag) begin
        err_flag = 1'b1;
        err_off  = off;
      end
      due_q.push_back(r);
    endfunction

    // one U+FFFD per byte of the failed sequence, offsets from its lead byte
    function void add_replacements(int unsigned count);
      for (int unsigned k = 0; k < count && k < 4; k++)
        add_result(REPL_CP, 1'b1, 3'd1, off_plus(lead_off, k));
    endfunction

    function void decode_byte(logic [7:0] b, logic fin);
      logic [31:0]    pos;
      bit             fresh;
      int unsigned    first;
      int unsigned    held;
      int unsigned    w;
      logic [20:0]    lead_bits;
      bit             overlong;
      decode_result_t r;
      pos   = next_off;
      fresh = 1'b1;
      first = due_q.size();
      if (held_cnt != 0) begin
        if (b[7:6] == 2'b10) begin
          fresh = 1'b0;
          acc   = {acc[14:0], b[5:0]};
          held  = held_cnt + 1;
          if (held >= seq_width) begin
            overlong = (seq_width == 2 && acc < MIN_CP_2) ||
                       (seq_width == 3 && acc < MIN_CP_3) ||
                       (seq_width == 4 && acc < MIN_CP_4);
            if (!overlong && acc <= CP_MAX && (acc < SURR_LO || acc > SURR_HI))
              add_result(acc, 1'b0, 3'(seq_width), lead_off);
            else
              add_replacements(seq_width);
            held_cnt = 0;
          end else if (fin) begin
            add_replacements(held);
            held_cnt = 0;
          end else begin
            held_cnt = held;
          end
        end else begin
          add_replacements(held_cnt);
          held_cnt = 0;
        end
      end
      if (fresh) begin
        w         = 0;
        lead_bits = '0;
        if (b[7] == 1'b0) begin
          add_result(21'(b), 1'b0, 3'd1, pos);
        end else begin
          if (b[7:5] == 3'b110) begin
            w = 2; lead_bits = 21'(b[4:0]);
          end else if (b[7:4] == 4'b1110) begin
            w = 3; lead_bits = 21'(b[3:0]);
          end else if (b[7:3] == 5'b11110) begin
            w = 4; lead_bits = 21'(b[2:0]);
          end
          if (w == 0 || fin) begin
            add_result(REPL_CP, 1'b1, 3'd1, pos);
          end else begin
            held_cnt  = 1;
            seq_width = w;
            acc       = lead_bits;
            lead_off  = pos;
          end
        end
      end
      next_off = off_plus(pos, 1);
      if (due_q.size() > first) begin
        r = due_q.pop_back();
        r.run_last = 1'b1;
        if (fin) begin
          r.text_end   = 1'b1;
          r.text_valid = !err_flag;
          r.first_bad  = err_flag ? err_off : '0;
        end
        due_q.push_back(r);
      end
      if (fin) clear_text();
    endfunction

    function void report(string why, decode_result_t want, decode_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", why);
        $display("  exp cp=%h bad=%0d len=%0d off=%0d idx=%0d last=%0d end=%0d ok=%0d fbo=%0d",
                 want.cp, want.bad, want.len, want.off, want.idx, want.run_last,
                 want.text_end, want.text_valid, want.first_bad);
        $display("  got cp=%h bad=%0d len=%0d off=%0d idx=%0d last=%0d end=%0d ok=%0d fbo=%0d",
                 got.cp, got.bad, got.len, got.off, got.idx, got.run_last,
                 got.text_end, got.text_valid, got.first_bad);
      end
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t want;
      if (due_q.size() == 0) begin
        report("result with nothing due", '0, got);
      end else begin
        want = due_q.pop_front();
        if (want !== got) report("result mismatch", want, got);
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_BYTES = 90;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = '0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [20:0] codepoint_o;
  logic        malformed_o;
  logic [2:0]  seq_bytes_o;
  logic [31:0] seq_offset_o;
  logic [31:0] cp_index_o;
  logic        run_last_o;
  logic        text_end_o;
  logic        text_valid_o;
  logic [31:0] first_bad_offset_o;

  utf8_scoreboard sb;
  logic [7:0]     text_q[$];
  int             idle_pct  = 0;
  int             stall_pct = 0;
  int             hold_req  = 0;
  int             hold_seen = 0;
  int             hold_left = 0;
  int             cycle_cnt = 0;
  decode_result_t got;

  utf8_stream_decode_validate_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .byte_value_i       (byte_value_i),
    .final_byte_i       (final_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .codepoint_o        (codepoint_o),
    .malformed_o        (malformed_o),
    .seq_bytes_o        (seq_bytes_o),
    .seq_offset_o       (seq_offset_o),
    .cp_index_o         (cp_index_o),
    .run_last_o         (run_last_o),
    .text_end_o         (text_end_o),
    .text_valid_o       (text_valid_o),
    .first_bad_offset_o (first_bad_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.decode_byte(byte_value_i, final_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.cp         = codepoint_o;
        got.bad        = malformed_o;
        got.len        = seq_bytes_o;
        got.off        = seq_offset_o;
        got.idx        = cp_index_o;
        got.run_last   = run_last_o;
        got.text_end   = text_end_o;
        got.text_valid = text_valid_o;
        got.first_bad  = first_bad_offset_o;
        sb.check_result(got);
      end
    end
  end

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_packed(input logic [63:0] w, input int n);
    text_q.delete();
    for (int i = 0; i < n; i++) text_q.push_back(w[8*(n-1-i) +: 8]);
    send_text();
  endtask

  // one edge first so the last transfer is in the scoreboard
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void push_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      text_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_q.push_back({3'b110, cp[10:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_q.push_back({4'b1110, cp[15:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end else begin
      text_q.push_back({5'b11110, cp[20:18]});
      text_q.push_back({2'b10, cp[17:12]});
      text_q.push_back({2'b10, cp[11:6]});
      text_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] rand_scalar();
    logic [20:0] cp;
    case ($urandom_range(0, 3))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void build_text();
    int units;
    int pick;
    int keep;
    text_q.delete();
    units = $urandom_range(1, 8);
    for (int u = 0; u < units; u++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_cp(rand_scalar());
      end else if (pick < 80) begin
        // overlong, surrogate and out-of-range forms
        case ($urandom_range(0, 5))
          0: begin
            text_q.push_back(8'hC0 | 8'($urandom_range(0, 1)));
            text_q.push_back(cont_byte());
          end
          1: begin
            text_q.push_back(8'hE0);
            text_q.push_back(8'h80 | 8'($urandom_range(0, 31)));
            text_q.push_back(cont_byte());
          end
          2: begin
            text_q.push_back(8'hF0);
            text_q.push_back(8'h80 | 8'($urandom_range(0, 15)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
          3: begin
            text_q.push_back(8'hED);
            text_q.push_back(8'hA0 | 8'($urandom_range(0, 31)));
            text_q.push_back(cont_byte());
          end
          4: begin
            text_q.push_back(8'hF4);
            text_q.push_back(8'h90 + 8'($urandom_range(0, 47)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
          default: begin
            text_q.push_back(8'hF5 + 8'($urandom_range(0, 2)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
          end
        endcase
      end else if (pick < 90) begin
        // truncated multi-byte sequence
        keep = text_q.size();
        push_cp(21'($urandom_range('h80, 'h10FFFF)) | 21'h80);
        keep = keep + $urandom_range(1, text_q.size() - keep - 1);
        while (text_q.size() > keep) void'(text_q.pop_back());
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin
    int sent;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_packed(64'h7F_C2_80, 3);           // ASCII max, smallest two-byte
    send_packed(64'hF4_8F_BF_BF, 4);        // largest scalar
    send_packed(64'hC0_80, 2);              // overlong two-byte form
    send_packed(64'hED_A0_80, 3);           // surrogate
    send_packed(64'hF5_80_80_80, 4);        // lead above range
    send_packed(64'hF0_90_80_41, 4);        // broken sequence, byte decoded afresh
    send_packed(64'hFF_80_E2, 3);           // bad lead, stray continuation, final lead
    send_packed(64'hE2_82, 2);              // truncated at text end
    wait_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      // long receiver hold-off while bytes keep coming
      if (phase == 0) hold_req++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_text();
        sent += text_q.size();
        send_text();
      end
      wait_drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
